// ===== hdl/ehd_pkg.sv =====
// Package for the holy-day date block: field widths, queue sizing,
// holy-day codes, offsets from Easter and the ordinal-to-date helper.
// No dependencies.
package ehd_pkg;

    localparam int YEAR_W      = 16;
    localparam int ORD_W       = 7;
    localparam int HOLY_W      = 3;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int NUM_STAGES  = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // computus constants
    localparam int DATE_BASE   = 114;
    localparam int M_LIMIT     = 451;

    // last day of each month in a common year
    localparam logic [8:0] CUM_END [12] = '{
        9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    typedef enum logic [HOLY_W-1:0] {
        HOLY_CARN_SUN = 3'd0,
        HOLY_CARN_MON = 3'd1,
        HOLY_CARN_TUE = 3'd2,
        HOLY_GOOD_FRI = 3'd3,
        HOLY_EASTER   = 3'd4,
        HOLY_ASCENSION = 3'd5,
        HOLY_WHITSUN  = 3'd6
    } t_holy_day;

    // one year's Easter, as handed from the front end to the back end
    typedef struct packed {
        logic [ORD_W-1:0] ordinal;
        logic             leap;
    } t_entry;

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    // signed distance of each holy day from Easter Sunday
    function automatic logic signed [8:0] ehd_offset(input t_holy_day hd);
        logic signed [8:0] r;
        unique case (hd)
            HOLY_CARN_SUN:  r = -9'sd49;
            HOLY_CARN_MON:  r = -9'sd48;
            HOLY_CARN_TUE:  r = -9'sd47;
            HOLY_GOOD_FRI:  r = -9'sd2;
            HOLY_EASTER:    r = 9'sd0;
            HOLY_ASCENSION: r = 9'sd39;
            HOLY_WHITSUN:   r = 9'sd49;
            default:        r = 9'sd0;
        endcase
        return r;
    endfunction

    // x mod 7 for x below 128: sum the octal digits, then fold twice
    function automatic logic [2:0] ehd_mod7(input logic [6:0] x);
        logic [3:0] s;
        s = {3'd0, x[6]} + {1'b0, x[5:3]} + {1'b0, x[2:0]};
        if (s >= 4'd7) s = s - 4'd7;
        if (s >= 4'd7) s = s - 4'd7;
        return s[2:0];
    endfunction

    // day of year to month and day of month; past November falls to December
    function automatic t_date ehd_to_date(input logic [7:0] n, input logic leap);
        t_date      r;
        logic [8:0] lo;
        logic [8:0] hi;
        logic [8:0] nx;
        logic       done;
        nx      = {1'b0, n};
        lo      = '0;
        hi      = '0;
        done    = 1'b0;
        r.month = MONTH_W'(12);
        r.day   = '0;
        for (int m = 0; m < 11; m++) begin
            hi = CUM_END[m] + ((m > 0 && leap) ? 9'd1 : 9'd0);
            if (!done && nx <= hi) begin
                r.month = MONTH_W'(m + 1);
                r.day   = DAY_W'(nx - lo);
                done    = 1'b1;
            end
            lo = hi;
        end
        if (!done) begin
            r.day = DAY_W'(nx - lo);
        end
        return r;
    endfunction

endpackage

// ===== hdl/ehd_front.sv =====
// Front end: seven-stage computus pipeline from year to Easter day of year.
// Depends on ehd_pkg; writes one t_entry per year into the queue.
module ehd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [ehd_pkg::YEAR_W-1:0] i_year,
    output logic                   o_push,
    output ehd_pkg::t_entry        o_entry,
    input  logic                   i_full
);
    import ehd_pkg::*;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_en;

    // stage 1: reciprocal estimates of year/100 and year/19
    logic [25:0] w_p100;
    logic [27:0] w_p19;
    logic [15:0] r1_year;
    logic [9:0]  r1_q100;
    logic [11:0] r1_q19;

    // stage 2: corrected quotients and remainders, leap flag
    logic [15:0] w_r100;
    logic [15:0] w_r19;
    logic        w_hi100;
    logic        w_hi19;
    logic [9:0]  w_b;
    logic [6:0]  w_c;
    logic [4:0]  r2_a;
    logic [9:0]  r2_b;
    logic [6:0]  r2_c;
    logic        r2_leap;

    // stage 3: f = (b + 8) / 25
    logic [9:0]  w_b8;
    logic [15:0] w_pf;
    logic [4:0]  r3_a;
    logic [9:0]  r3_b;
    logic [4:0]  r3_f;
    logic [1:0]  r3_e;
    logic [4:0]  r3_i;
    logic [1:0]  r3_k;
    logic        r3_leap;

    // stage 4: g = (b - f + 1) / 3
    logic [9:0]  w_xg;
    logic [18:0] w_pg;
    logic [4:0]  r4_a;
    logic [9:0]  r4_b;
    logic [7:0]  r4_g;
    logic [1:0]  r4_e;
    logic [4:0]  r4_i;
    logic [1:0]  r4_k;
    logic        r4_leap;

    // stage 5: operand of h and its quotient by 30
    logic [10:0] w_xh;
    logic [20:0] w_ph;
    logic [4:0]  r5_a;
    logic [9:0]  r5_xh;
    logic [5:0]  r5_qh;
    logic [1:0]  r5_e;
    logic [4:0]  r5_i;
    logic [1:0]  r5_k;
    logic        r5_leap;

    // stage 6: h, operand of l
    logic [4:0]  w_h;
    logic [6:0]  w_xl;
    logic [4:0]  r6_a;
    logic [4:0]  r6_h;
    logic [6:0]  r6_xl;
    logic        r6_leap;

    // stage 7: l
    logic [4:0]  r7_a;
    logic [4:0]  r7_h;
    logic [2:0]  r7_l;
    logic        r7_leap;

    // queue write: month correction and day of year
    logic [8:0]  w_s;
    logic        w_m;
    logic [7:0]  w_base;
    logic        w_april;
    logic [7:0]  w_dom;
    logic [7:0]  w_ord;

    // stage enables: a stage takes new data when empty or when it drains
    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_full;
        for (int s = NUM_STAGES - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    assign o_stall = !w_en[0];
    assign o_push  = r_vld[NUM_STAGES-1] && !i_full;

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < NUM_STAGES; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    assign w_p100 = {10'd0, i_year} * 26'd655;
    assign w_p19  = {12'd0, i_year} * 28'd3449;

    assign w_r100  = r1_year - ({6'd0, r1_q100} * 16'd100);
    assign w_r19   = r1_year - ({4'd0, r1_q19} * 16'd19);
    assign w_hi100 = (w_r100 >= 16'd100);
    assign w_hi19  = (w_r19 >= 16'd19);
    assign w_b     = w_hi100 ? (r1_q100 + 10'd1) : r1_q100;
    assign w_c     = w_hi100 ? 7'(w_r100 - 16'd100) : 7'(w_r100);

    assign w_b8 = r2_b + 10'd8;
    assign w_pf = {6'd0, w_b8} * 16'd41;

    assign w_xg = r3_b - {5'd0, r3_f} + 10'd1;
    assign w_pg = {9'd0, w_xg} * 19'd683;

    assign w_xh = ({6'd0, r4_a} * 11'd19) + {1'b0, r4_b} + 11'd15
                - {3'd0, r4_b[9:2]} - {3'd0, r4_g};
    assign w_ph = {11'd0, w_xh[9:0]} * 21'd1093;

    assign w_h  = 5'(r5_xh - ({4'd0, r5_qh} * 10'd30));
    assign w_xl = 7'd32 + {4'd0, r5_e, 1'b0} + {1'b0, r5_i, 1'b0}
                - {2'd0, w_h} - {5'd0, r5_k};

    assign w_s     = {4'd0, r7_a} + ({4'd0, r7_h} * 9'd11) + ({6'd0, r7_l} * 9'd22);
    assign w_m     = (w_s >= 9'(M_LIMIT));
    assign w_base  = {3'd0, r7_h} + {5'd0, r7_l} + 8'(DATE_BASE) - (w_m ? 8'd7 : 8'd0);
    assign w_april = (w_base >= 8'd124);
    assign w_dom   = w_april ? (w_base - 8'd123) : (w_base - 8'd92);
    assign w_ord   = 8'd59 + {7'd0, r7_leap} + w_dom + (w_april ? 8'd31 : 8'd0);

    assign o_entry.ordinal = w_ord[ORD_W-1:0];
    assign o_entry.leap    = r7_leap;

    // pipeline payload, held while a stage is blocked
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_year <= i_year;
            r1_q100 <= w_p100[25:16];
            r1_q19  <= w_p19[27:16];
        end
        if (w_en[1]) begin
            r2_a    <= w_hi19 ? 5'(w_r19 - 16'd19) : 5'(w_r19);
            r2_b    <= w_b;
            r2_c    <= w_c;
            r2_leap <= (w_c == 7'd0) ? (w_b[1:0] == 2'd0) : (r1_year[1:0] == 2'd0);
        end
        if (w_en[2]) begin
            r3_a    <= r2_a;
            r3_b    <= r2_b;
            r3_f    <= 5'(w_pf >> 10);
            r3_e    <= r2_b[1:0];
            r3_i    <= r2_c[6:2];
            r3_k    <= r2_c[1:0];
            r3_leap <= r2_leap;
        end
        if (w_en[3]) begin
            r4_a    <= r3_a;
            r4_b    <= r3_b;
            r4_g    <= 8'(w_pg >> 11);
            r4_e    <= r3_e;
            r4_i    <= r3_i;
            r4_k    <= r3_k;
            r4_leap <= r3_leap;
        end
        if (w_en[4]) begin
            r5_a    <= r4_a;
            r5_xh   <= w_xh[9:0];
            r5_qh   <= 6'(w_ph >> 15);
            r5_e    <= r4_e;
            r5_i    <= r4_i;
            r5_k    <= r4_k;
            r5_leap <= r4_leap;
        end
        if (w_en[5]) begin
            r6_a    <= r5_a;
            r6_h    <= w_h;
            r6_xl   <= w_xl;
            r6_leap <= r5_leap;
        end
        if (w_en[6]) begin
            r7_a    <= r6_a;
            r7_h    <= r6_h;
            r7_l    <= ehd_mod7(r6_xl);
            r7_leap <= r6_leap;
        end
    end

endmodule

// ===== hdl/ehd_queue.sv =====
// Short register queue between the computus front end and the date back end.
// Depends on ehd_pkg for the entry type and depth.
module ehd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ehd_pkg::t_entry i_entry,
    output logic            o_full,
    output logic            o_head_vld,
    output ehd_pkg::t_entry o_head,
    input  logic            i_pop
);
    import ehd_pkg::*;

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full     = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_head_vld = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== hdl/ehd_back.sv =====
// Back end: expands one Easter entry into seven holy-day result beats.
// Depends on ehd_pkg for codes, offsets and the date conversion.
module ehd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_head_vld,
    input  ehd_pkg::t_entry             i_head,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ehd_pkg::HOLY_W-1:0]  o_holy_day,
    output logic [ehd_pkg::MONTH_W-1:0] o_month,
    output logic [ehd_pkg::DAY_W-1:0]   o_day,
    output logic                        o_last
);
    import ehd_pkg::*;

    t_holy_day          r_k;
    logic               r_valid;
    logic [HOLY_W-1:0]  r_holy_day;
    logic [MONTH_W-1:0] r_month;
    logic [DAY_W-1:0]   r_day;
    logic               r_last;

    logic               w_load;
    logic               w_is_last;
    logic signed [8:0]  w_n;
    logic [7:0]         w_nc;
    t_date              w_date;

    // output register takes a beat when empty or when its beat leaves
    assign w_load    = i_head_vld && (!r_valid || !i_stall);
    assign w_is_last = (r_k == HOLY_WHITSUN);
    assign o_pop     = w_load && w_is_last;

    // day of year of the current holy day, clamped to the first of January
    assign w_n    = $signed({2'b00, i_head.ordinal}) + ehd_offset(r_k);
    assign w_nc   = (w_n < 9'sd1) ? 8'd1 : w_n[7:0];
    assign w_date = ehd_to_date(w_nc, i_head.leap);

    // step through the holy days and hold the output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= HOLY_CARN_SUN;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_k     <= w_is_last ? HOLY_CARN_SUN : t_holy_day'(r_k + 3'd1);
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_holy_day <= r_k;
            r_month    <= w_date.month;
            r_day      <= w_date.day;
            r_last     <= w_is_last;
        end
    end

    assign o_valid    = r_valid;
    assign o_holy_day = r_holy_day;
    assign o_month    = r_month;
    assign o_day      = r_day;
    assign o_last     = r_last;

endmodule

// ===== hdl/easter_holy_day_dates.sv =====
// Top level of the holy-day date block: front end, queue and back end.
// Depends on ehd_pkg, ehd_front, ehd_queue and ehd_back.
//
// Input channel: i_valid / o_stall with i_year. A year is taken at a rising
// edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_holy_day, o_month, o_day, o_last.
// Each year gives seven beats in code order, carnival Sunday to Whitsuntide;
// o_last marks the Whitsuntide beat.
// A year taken into the first computus stage passes six more computus stages,
// the queue and the output register before its first beat shows on o_valid.
// Throughput: one beat per cycle while i_stall is low; the seven beats of
// a year on the one output channel bound the rate of years. The front end
// takes a year every cycle until its pipeline and the four-entry queue fill.
// When the receiver stalls the output beat holds, the back end stops, the
// queue fills and o_stall rises once the front pipeline is full.
// Reset (i_rst_n low, synchronous) empties pipeline, queue and output.
module easter_holy_day_dates (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ehd_pkg::YEAR_W-1:0]  i_year,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ehd_pkg::HOLY_W-1:0]  o_holy_day,
    output logic [ehd_pkg::MONTH_W-1:0] o_month,
    output logic [ehd_pkg::DAY_W-1:0]   o_day,
    output logic                        o_last
);
    import ehd_pkg::*;

    logic   w_push;
    logic   w_full;
    logic   w_head_vld;
    logic   w_pop;
    t_entry w_entry;
    t_entry w_head;

    ehd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_year  (i_year),
        .o_push  (w_push),
        .o_entry (w_entry),
        .i_full  (w_full)
    );

    ehd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_entry    (w_entry),
        .o_full     (w_full),
        .o_head_vld (w_head_vld),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    ehd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head_vld (w_head_vld),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_holy_day (o_holy_day),
        .o_month    (o_month),
        .o_day      (o_day),
        .o_last     (o_last)
    );

    // the last beat of a year is always Whitsuntide
    a_last_is_whitsun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_holy_day == HOLY_WHITSUN)
        else $error("last beat is not whitsuntide");

    // a taken beat that is not last is followed at once by the next code
    a_codes_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last
        |=> o_valid && (o_holy_day == $past(o_holy_day) + 3'd1))
        else $error("holy-day beats out of order or broken up");

    // every holy day lies between February and June
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month >= 4'd2) && (o_month <= 4'd6) && (o_day != 5'd0))
        else $error("holy-day date out of range");

    // the queue never takes an entry while full
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push)
        else $error("queue overrun");

endmodule
